[sv/decimal_fixed_point_alu_core_assert.svh]
// Assertion macros for the decimal fixed-point ALU core.
// Needs signals named clk and rst in the scope where a macro is used.
`ifndef DECIMAL_FIXED_POINT_ALU_CORE_ASSERT_SVH
`define DECIMAL_FIXED_POINT_ALU_CORE_ASSERT_SVH
// Checks that cons holds in the same cycle as ante.
`define DFPA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("decimal ALU check failed");
// Checks that cons holds in the cycle after ante.
`define DFPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("decimal ALU check failed");
`endif

[sv/dfpa_pkg.sv]
// Shared types, codes and constant functions of the decimal fixed-point ALU.
// Has no dependencies; every other file of the block but the assertion header uses it.
package dfpa_pkg;

  localparam int unsigned MAX_PRECISION = 18;
  localparam int unsigned VALUE_W       = 64;
  localparam int unsigned PREC_W        = 5;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    op_t                       op;
    logic signed [VALUE_W-1:0] a_value;
    logic        [PREC_W-1:0]  a_precision;
    logic signed [VALUE_W-1:0] b_value;
    logic        [PREC_W-1:0]  b_precision;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] result_value;
    logic        [PREC_W-1:0]  result_precision;
    status_t                   status;
  } rsp_t;

  typedef struct packed {
    logic              v;
    op_t               op;
    logic              na;
    logic              nb;
    logic              neg;
    logic              dz;
    logic [PREC_W-1:0] prec;
  } ctl_t;

  function automatic int unsigned pow10_bits(int unsigned n);
    logic [255:0] v;
    int unsigned  b;
    v = 256'd1;
    b = 0;
    for (int unsigned i = 0; i < n; i++) begin
      v = v * 256'd10;
    end
    for (int unsigned i = 0; i < 256; i++) begin
      if (v[i]) begin
        b = i + 1;
      end
    end
    return b;
  endfunction

  function automatic logic [63:0] pow10(int unsigned n);
    logic [63:0] v;
    v = 64'd1;
    for (int unsigned i = 0; i < n; i++) begin
      v = v * 64'd10;
    end
    return v;
  endfunction

endpackage

[sv/dfpa_align.sv]
// Alignment pipeline: one conditional multiply by ten per stage on each operand.
// Depends on dfpa_pkg.
module dfpa_align #(
  parameter int unsigned MAX_PRECISION = dfpa_pkg::MAX_PRECISION,
  parameter int unsigned AW = dfpa_pkg::VALUE_W + dfpa_pkg::pow10_bits(2 * MAX_PRECISION),
  parameter int unsigned BW = dfpa_pkg::VALUE_W + dfpa_pkg::pow10_bits(MAX_PRECISION),
  parameter int unsigned KW = $clog2(2 * MAX_PRECISION + 2)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  dfpa_pkg::ctl_t             ctl_i,
  input  logic [dfpa_pkg::VALUE_W-1:0] a_i,
  input  logic [dfpa_pkg::VALUE_W-1:0] b_i,
  input  logic [KW-1:0]              ka_i,
  input  logic [KW-1:0]              kb_i,
  output dfpa_pkg::ctl_t             ctl_o,
  output logic [AW-1:0]              a_o,
  output logic [BW-1:0]              b_o
);

  localparam int unsigned NS = (MAX_PRECISION > 0) ? 2 * MAX_PRECISION : 1;

  dfpa_pkg::ctl_t c_q  [NS];
  logic [AW-1:0]  a_q  [NS];
  logic [BW-1:0]  b_q  [NS];
  logic [KW-1:0]  ka_q [NS];
  logic [KW-1:0]  kb_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    dfpa_pkg::ctl_t c_in;
    logic [AW-1:0]  a_in;
    logic [BW-1:0]  b_in;
    logic [KW-1:0]  ka_in;
    logic [KW-1:0]  kb_in;

    if (s == 0) begin : g_first
      assign c_in  = ctl_i;
      assign a_in  = AW'(a_i);
      assign b_in  = BW'(b_i);
      assign ka_in = ka_i;
      assign kb_in = kb_i;
    end else begin : g_next
      assign c_in  = c_q[s-1];
      assign a_in  = a_q[s-1];
      assign b_in  = b_q[s-1];
      assign ka_in = ka_q[s-1];
      assign kb_in = kb_q[s-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        c_q[s].v <= 1'b0;
      end else if (adv) begin
        c_q[s] <= c_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        a_q[s]  <= (ka_in > KW'(s)) ? (a_in << 3) + (a_in << 1) : a_in;
        b_q[s]  <= (kb_in > KW'(s)) ? (b_in << 3) + (b_in << 1) : b_in;
        ka_q[s] <= ka_in;
        kb_q[s] <= kb_in;
      end
    end
  end

  assign ctl_o = c_q[NS-1];
  assign a_o   = a_q[NS-1];
  assign b_o   = b_q[NS-1];

endmodule

[sv/dfpa_comb.sv]
// Operand combine pipeline: add or subtract, limb-wise multiply with a summing
// tree, and selection of dividend and divisor. Depends on dfpa_pkg.
module dfpa_comb #(
  parameter int unsigned MAX_PRECISION = dfpa_pkg::MAX_PRECISION,
  parameter int unsigned AW = dfpa_pkg::VALUE_W + dfpa_pkg::pow10_bits(2 * MAX_PRECISION),
  parameter int unsigned BW = dfpa_pkg::VALUE_W + dfpa_pkg::pow10_bits(MAX_PRECISION),
  parameter int unsigned NW = (AW > 2 * BW) ? AW : 2 * BW
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  dfpa_pkg::ctl_t ctl_i,
  input  logic [AW-1:0]  a_i,
  input  logic [BW-1:0]  b_i,
  output dfpa_pkg::ctl_t ctl_o,
  output logic [NW-1:0]  n_o,
  output logic [BW-1:0]  d_o
);

  localparam int unsigned L  = (BW + 31) / 32;
  localparam int unsigned LW = 32 * L;
  localparam int unsigned PW = 2 * LW;

  logic [63:0] p10 [32];
  for (genvar g = 0; g < 32; g++) begin : g_p10
    assign p10[g] = dfpa_pkg::pow10(g);
  end

  logic [BW-1:0] a_lo;
  logic [LW-1:0] am;
  logic [LW-1:0] bm;
  assign a_lo = a_i[BW-1:0];
  assign am   = LW'(a_lo);
  assign bm   = LW'(b_i);

  logic           nb_eff;
  logic           sneg;
  logic [BW:0]    sum;
  dfpa_pkg::ctl_t c1_next;
  logic [NW-1:0]  nalt_next;
  logic [BW-1:0]  d_next;

  always_comb begin
    nb_eff = ctl_i.nb ^ (ctl_i.op == dfpa_pkg::OP_SUB);
    if (ctl_i.na == nb_eff) begin
      sum  = {1'b0, a_lo} + {1'b0, b_i};
      sneg = ctl_i.na;
    end else if (a_lo >= b_i) begin
      sum  = {1'b0, a_lo} - {1'b0, b_i};
      sneg = ctl_i.na;
    end else begin
      sum  = {1'b0, b_i} - {1'b0, a_lo};
      sneg = nb_eff;
    end
    c1_next = ctl_i;
    unique case (ctl_i.op)
      dfpa_pkg::OP_ADD, dfpa_pkg::OP_SUB: begin
        c1_next.neg = sneg;
        nalt_next   = NW'(sum);
        d_next      = BW'(1);
      end
      dfpa_pkg::OP_MUL: begin
        nalt_next = '0;
        d_next    = BW'(p10[ctl_i.prec]);
      end
      dfpa_pkg::OP_DIV: begin
        nalt_next = NW'(a_i);
        d_next    = b_i;
      end
      default: begin
        nalt_next = '0;
        d_next    = '0;
      end
    endcase
  end

  dfpa_pkg::ctl_t c1;
  dfpa_pkg::ctl_t c2;
  dfpa_pkg::ctl_t c3;
  logic [63:0]   pp [L][L];
  logic [NW-1:0] nalt1;
  logic [NW-1:0] nalt2;
  logic [BW-1:0] d1;
  logic [BW-1:0] d2;
  logic [PW-1:0] rows [L];
  logic [PW-1:0] rows_next [L];
  logic [PW-1:0] total_next;
  logic [NW-1:0] n3;
  logic [BW-1:0] d3;

  always_comb begin
    for (int i = 0; i < L; i++) begin
      rows_next[i] = '0;
      for (int j = 0; j < L; j++) begin
        rows_next[i] = rows_next[i] + (PW'(pp[i][j]) << (32 * j));
      end
    end
  end

  always_comb begin
    total_next = '0;
    for (int i = 0; i < L; i++) begin
      total_next = total_next + (rows[i] << (32 * i));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1.v <= 1'b0;
      c2.v <= 1'b0;
      c3.v <= 1'b0;
    end else if (adv) begin
      c1 <= c1_next;
      c2 <= c1;
      c3 <= c2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < L; i++) begin
        for (int j = 0; j < L; j++) begin
          pp[i][j] <= {32'b0, am[32*i +: 32]} * {32'b0, bm[32*j +: 32]};
        end
      end
      nalt1 <= nalt_next;
      d1    <= d_next;
      rows  <= rows_next;
      nalt2 <= nalt1;
      d2    <= d1;
      n3    <= (c2.op == dfpa_pkg::OP_MUL) ? NW'(total_next) : nalt2;
      d3    <= d2;
    end
  end

  assign ctl_o = c3;
  assign n_o   = n3;
  assign d_o   = d3;

endmodule

[sv/dfpa_div.sv]
// Pipelined restoring divider: a range check stage, then one quotient bit per
// stage for a 64-bit quotient and its remainder. Depends on dfpa_pkg.
module dfpa_div #(
  parameter int unsigned NW = 248,
  parameter int unsigned DW = 124
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  dfpa_pkg::ctl_t ctl_i,
  input  logic [NW-1:0]  n_i,
  input  logic [DW-1:0]  d_i,
  output dfpa_pkg::ctl_t ctl_o,
  output logic           ovf_o,
  output logic [63:0]    q_o,
  output logic [DW:0]    r_o,
  output logic [DW-1:0]  d_o
);

  localparam int unsigned QW = 64;
  localparam int unsigned NS = QW + 1;
  localparam int unsigned HW = NW - QW;
  localparam int unsigned CW = (HW > DW) ? HW : DW;

  dfpa_pkg::ctl_t c_q [NS];
  logic           o_q [NS];
  logic [QW-1:0]  q_q [NS];
  logic [DW:0]    r_q [NS];
  logic [DW-1:0]  d_q [NS];

  logic [HW-1:0] hi;
  assign hi = n_i[NW-1:QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_q[0].v <= 1'b0;
    end else if (adv) begin
      c_q[0] <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_q[0] <= CW'(hi) >= CW'(d_i);
      r_q[0] <= (DW+1)'(hi);
      q_q[0] <= n_i[QW-1:0];
      d_q[0] <= d_i;
    end
  end

  for (genvar s = 1; s < NS; s++) begin : g_stage
    logic [DW+1:0] t;
    logic          ge;
    assign t  = {r_q[s-1], q_q[s-1][QW-1]};
    assign ge = t >= (DW+2)'(d_q[s-1]);

    always_ff @(posedge clk) begin
      if (rst) begin
        c_q[s].v <= 1'b0;
      end else if (adv) begin
        c_q[s] <= c_q[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        o_q[s] <= o_q[s-1];
        r_q[s] <= ge ? (DW+1)'(t - (DW+2)'(d_q[s-1])) : (DW+1)'(t);
        q_q[s] <= {q_q[s-1][QW-2:0], ge};
        d_q[s] <= d_q[s-1];
      end
    end
  end

  assign ctl_o = c_q[NS-1];
  assign ovf_o = o_q[NS-1];
  assign q_o   = q_q[NS-1];
  assign r_o   = r_q[NS-1];
  assign d_o   = d_q[NS-1];

endmodule

[sv/decimal_fixed_point_alu_core.sv]
// Decimal fixed-point ALU: add, subtract, multiply and divide of scaled decimals.
// Depends on dfpa_pkg, dfpa_align, dfpa_comb, dfpa_div and the assertion header.
//
// Usage: a request beat on req_valid/req_ready carries the operation and two
// operands, each a signed 64-bit scaled integer with its digit count. A
// response beat on rsp_valid/rsp_ready carries the result at the larger of the
// two precisions (each capped at MAX_PRECISION), saturated on overflow, with a status code.
// From request beat to response beat the pipeline has one decode stage, one
// multiply-by-ten stage per alignment digit (at least one), three multiply and
// combine stages, a range check, one stage per quotient bit of the 64-bit
// divider, and the output register. Throughput is one beat per cycle unless
// the receiver stalls; every stage is fully pipelined.
// The whole pipeline advances whenever the output register is empty or taken,
// so req_ready is high exactly then. When the receiver stalls, every stage holds
// its contents and req_ready is low; nothing is lost or repeated.
// Reset clears all valid bits; no response is pending after it.
module decimal_fixed_point_alu_core #(
  parameter int unsigned MAX_PRECISION = dfpa_pkg::MAX_PRECISION
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  dfpa_pkg::req_t req_data,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output dfpa_pkg::rsp_t rsp_data
);

  localparam int unsigned AW = dfpa_pkg::VALUE_W + dfpa_pkg::pow10_bits(2 * MAX_PRECISION);
  localparam int unsigned BW = dfpa_pkg::VALUE_W + dfpa_pkg::pow10_bits(MAX_PRECISION);
  localparam int unsigned NW = (AW > 2 * BW) ? AW : 2 * BW;
  localparam int unsigned KW = $clog2(2 * MAX_PRECISION + 2);
  localparam logic [dfpa_pkg::PREC_W-1:0] PREC_MAX = dfpa_pkg::PREC_W'(MAX_PRECISION);
  localparam logic [64:0] NEG_LIM = 65'd1 << 63;
  localparam logic [64:0] POS_LIM = (65'd1 << 63) - 65'd1;

  logic adv;
  assign adv       = !rsp_valid || rsp_ready;
  assign req_ready = adv;

  logic [dfpa_pkg::PREC_W-1:0] pa;
  logic [dfpa_pkg::PREC_W-1:0] pb;
  logic [dfpa_pkg::PREC_W-1:0] p;
  logic [KW-1:0]               ka_next;
  logic [KW-1:0]               kb_next;
  logic [63:0]                 ma_next;
  logic [63:0]                 mb_next;
  dfpa_pkg::ctl_t              c0_next;

  always_comb begin
    pa = (req_data.a_precision > PREC_MAX) ? PREC_MAX : req_data.a_precision;
    pb = (req_data.b_precision > PREC_MAX) ? PREC_MAX : req_data.b_precision;
    p  = (pa > pb) ? pa : pb;
    ka_next = KW'(p) - KW'(pa) + ((req_data.op == dfpa_pkg::OP_DIV) ? KW'(p) : KW'(0));
    kb_next = KW'(p) - KW'(pb);
    ma_next = req_data.a_value[63] ? 64'(-req_data.a_value) : 64'(req_data.a_value);
    mb_next = req_data.b_value[63] ? 64'(-req_data.b_value) : 64'(req_data.b_value);
    c0_next.v    = req_valid;
    c0_next.op   = req_data.op;
    c0_next.na   = req_data.a_value[63];
    c0_next.nb   = req_data.b_value[63];
    c0_next.neg  = req_data.a_value[63] ^ req_data.b_value[63];
    c0_next.dz   = (req_data.op == dfpa_pkg::OP_DIV) && (req_data.b_value == 64'sd0);
    c0_next.prec = p;
  end

  dfpa_pkg::ctl_t c0;
  logic [63:0]    ma0;
  logic [63:0]    mb0;
  logic [KW-1:0]  ka0;
  logic [KW-1:0]  kb0;

  always_ff @(posedge clk) begin
    if (rst) begin
      c0.v <= 1'b0;
    end else if (adv) begin
      c0 <= c0_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ma0 <= ma_next;
      mb0 <= mb_next;
      ka0 <= ka_next;
      kb0 <= kb_next;
    end
  end

  dfpa_pkg::ctl_t al_ctl;
  logic [AW-1:0]  al_a;
  logic [BW-1:0]  al_b;

  dfpa_align #(
    .MAX_PRECISION (MAX_PRECISION),
    .AW            (AW),
    .BW            (BW),
    .KW            (KW)
  ) u_align (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .ctl_i (c0),
    .a_i   (ma0),
    .b_i   (mb0),
    .ka_i  (ka0),
    .kb_i  (kb0),
    .ctl_o (al_ctl),
    .a_o   (al_a),
    .b_o   (al_b)
  );

  dfpa_pkg::ctl_t cb_ctl;
  logic [NW-1:0]  cb_n;
  logic [BW-1:0]  cb_d;

  dfpa_comb #(
    .MAX_PRECISION (MAX_PRECISION),
    .AW            (AW),
    .BW            (BW),
    .NW            (NW)
  ) u_comb (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .ctl_i (al_ctl),
    .a_i   (al_a),
    .b_i   (al_b),
    .ctl_o (cb_ctl),
    .n_o   (cb_n),
    .d_o   (cb_d)
  );

  dfpa_pkg::ctl_t dv_ctl;
  logic           dv_ovf;
  logic [63:0]    dv_q;
  logic [BW:0]    dv_r;
  logic [BW-1:0]  dv_d;

  dfpa_div #(
    .NW (NW),
    .DW (BW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .ctl_i (cb_ctl),
    .n_i   (cb_n),
    .d_i   (cb_d),
    .ctl_o (dv_ctl),
    .ovf_o (dv_ovf),
    .q_o   (dv_q),
    .r_o   (dv_r),
    .d_o   (dv_d)
  );

  logic           rnd;
  logic [64:0]    mag;
  dfpa_pkg::rsp_t rsp_next;

  always_comb begin
    rnd = (dv_ctl.op == dfpa_pkg::OP_DIV) && ({dv_r, 1'b0} >= {2'b0, dv_d});
    mag = {1'b0, dv_q} + 65'(rnd);
    rsp_next.result_precision = dv_ctl.prec;
    if (dv_ctl.dz) begin
      rsp_next.result_value = '0;
      rsp_next.status       = dfpa_pkg::ST_DIV_ZERO;
    end else if (dv_ctl.neg) begin
      if (dv_ovf || mag > NEG_LIM) begin
        rsp_next.result_value = 64'h8000_0000_0000_0000;
        rsp_next.status       = dfpa_pkg::ST_OVERFLOW;
      end else begin
        rsp_next.result_value = 64'(65'd0 - mag);
        rsp_next.status       = dfpa_pkg::ST_OK;
      end
    end else begin
      if (dv_ovf || mag > POS_LIM) begin
        rsp_next.result_value = 64'h7FFF_FFFF_FFFF_FFFF;
        rsp_next.status       = dfpa_pkg::ST_OVERFLOW;
      end else begin
        rsp_next.result_value = 64'(mag);
        rsp_next.status       = dfpa_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= dv_ctl.v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp_data <= rsp_next;
    end
  end

  logic rsp_dz;
  assign rsp_dz = rsp_data.status == dfpa_pkg::ST_DIV_ZERO;

`include "decimal_fixed_point_alu_core_assert.svh"

  `DFPA_ASSERT_SAME(a_rem_below_divisor, dv_ctl.v && !dv_ovf, dv_r < {1'b0, dv_d})
  `DFPA_ASSERT_SAME(a_div_zero_value, rsp_valid && rsp_dz, rsp_data.result_value == 64'sd0)
  `DFPA_ASSERT_SAME(a_prec_in_range, rsp_valid, rsp_data.result_precision <= PREC_MAX)
  `DFPA_ASSERT_NEXT(a_stall_holds_pipe, rsp_valid && !rsp_ready, $stable(dv_q) && $stable(dv_ctl))

endmodule

[dv/decimal_fixed_point_alu_core_test.sv]
// Testbench for the decimal fixed-point ALU core: random and directed operand pairs.
// Depends on dfpa_pkg and decimal_fixed_point_alu_core; checks every response beat
// in order against a scoreboard that computes exact results with wide integers.
module decimal_fixed_point_alu_core_test;

  class alu_scoreboard;
    dfpa_pkg::rsp_t expected_q[$];
    int   mismatches = 0;

    function automatic dfpa_pkg::rsp_t compute(dfpa_pkg::req_t r);
      logic [63:0]          ua, ub;
      logic [255:0]         ma, mb, mr, t, rm, scale;
      logic signed [255:0]  sa, sb, sr;
      logic                 na, nb, nr;
      int unsigned          pa, pb, p;
      dfpa_pkg::rsp_t       o;
      pa = (r.a_precision > dfpa_pkg::MAX_PRECISION) ? dfpa_pkg::MAX_PRECISION
                                                      : r.a_precision;
      pb = (r.b_precision > dfpa_pkg::MAX_PRECISION) ? dfpa_pkg::MAX_PRECISION
                                                      : r.b_precision;
      p = (pa > pb) ? pa : pb;
      ua = r.a_value;
      ub = r.b_value;
      na = ua[63];
      nb = ub[63];
      ma = {192'd0, na ? -ua : ua};
      mb = {192'd0, nb ? -ub : ub};
      for (int unsigned k = pa; k < p; k++) ma = ma * 256'd10;
      for (int unsigned k = pb; k < p; k++) mb = mb * 256'd10;
      scale = 256'd1;
      for (int unsigned k = 0; k < p; k++) scale = scale * 256'd10;
      o.result_precision = p[4:0];
      o.status = dfpa_pkg::ST_OK;
      o.result_value = '0;
      nr = 1'b0;
      mr = '0;
      case (r.op)
        dfpa_pkg::OP_ADD, dfpa_pkg::OP_SUB: begin
          if (r.op == dfpa_pkg::OP_SUB) nb = !nb;
          sa = na ? -$signed(ma) : $signed(ma);
          sb = nb ? -$signed(mb) : $signed(mb);
          sr = sa + sb;
          nr = sr[255];
          mr = nr ? -sr : sr;
        end
        dfpa_pkg::OP_MUL: begin
          mr = (ma * mb) / scale;
          nr = na ^ nb;
        end
        default: begin
          if (mb == 0) begin
            o.status = dfpa_pkg::ST_DIV_ZERO;
          end else begin
            t = ma * scale;
            mr = t / mb;
            rm = t % mb;
            if ((rm << 1) >= mb) mr = mr + 256'd1;
            nr = na ^ nb;
          end
        end
      endcase
      if (o.status == dfpa_pkg::ST_OK) begin
        if (nr) begin
          if (mr > 256'h8000_0000_0000_0000) begin
            o.result_value = 64'h8000_0000_0000_0000;
            o.status = dfpa_pkg::ST_OVERFLOW;
          end else begin
            o.result_value = -mr[63:0];
          end
        end else begin
          if (mr > 256'h7FFF_FFFF_FFFF_FFFF) begin
            o.result_value = 64'h7FFF_FFFF_FFFF_FFFF;
            o.status = dfpa_pkg::ST_OVERFLOW;
          end else begin
            o.result_value = mr[63:0];
          end
        end
      end
      return o;
    endfunction

    function void note_request(dfpa_pkg::req_t r);
      expected_q.push_back(compute(r));
    endfunction

    function void check_response(dfpa_pkg::rsp_t got);
      dfpa_pkg::rsp_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected response beat: value %0d", got.result_value);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (got.result_value !== want.result_value) begin
        $error("result_value: expected %0d, actual %0d", want.result_value, got.result_value);
        mismatches++;
      end
      if (got.result_precision !== want.result_precision) begin
        $error("result_precision: expected %0d, actual %0d",
               want.result_precision, got.result_precision);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 1900;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  dfpa_pkg::req_t req_data = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  dfpa_pkg::rsp_t rsp_data;

  alu_scoreboard sb = new();
  int cycles = 0;

  decimal_fixed_point_alu_core dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
    if (!rst && req_valid && req_ready) sb.note_request(req_data);
    if (!rst && rsp_valid && rsp_ready) sb.check_response(rsp_data);
  end

  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    case ($urandom_range(4))
      0: begin
        case ($urandom_range(4))
          0: v = 64'h8000_0000_0000_0000;
          1: v = 64'h7FFF_FFFF_FFFF_FFFF;
          2: v = 64'd0;
          3: v = 64'd1;
          default: v = '1;
        endcase
      end
      1: v = 64'($urandom_range(2000)) - 64'd1000;
      2: v = {$urandom, $urandom} >> $urandom_range(63);
      3: v = dfpa_pkg::pow10($urandom_range(18)) * ($urandom_range(1) ? 64'd1 : '1);
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic logic [4:0] pick_precision();
    return ($urandom_range(9) == 0) ? 5'($urandom_range(31, 19)) : 5'($urandom_range(18));
  endfunction

  task automatic send_beat(dfpa_pkg::req_t r);
    req_data <= r;
    req_valid <= 1'b1;
    @(negedge clk);
    while (!req_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic idle_gap(bit allow);
    if (allow && $urandom_range(99) < 23) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  task automatic send_directed();
    dfpa_pkg::req_t r;
    logic [63:0] vals [5];
    vals[0] = 64'h8000_0000_0000_0000;
    vals[1] = 64'h7FFF_FFFF_FFFF_FFFF;
    vals[2] = 64'd0;
    vals[3] = 64'd12345;
    vals[4] = '1;
    for (int i = 0; i < 24; i++) begin
      r.op = dfpa_pkg::op_t'(i % 4);
      r.a_value = vals[i % 5];
      r.b_value = vals[(i / 4) % 5];
      r.a_precision = (i % 3 == 0) ? 5'd31 : 5'(i % 19);
      r.b_precision = (i % 5 == 0) ? 5'd0 : 5'd18;
      send_beat(r);
    end
    r.op = dfpa_pkg::OP_DIV;
    r.a_value = 64'd5;
    r.a_precision = 5'd0;
    r.b_value = 64'd10;
    r.b_precision = 5'd0;
    send_beat(r);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (cycles > 3000 && cycles <= 3400) begin
        rsp_ready <= 1'b0;
      end else if (cycles > 3400 && cycles <= 6000) begin
        rsp_ready <= 1'b1;
      end else begin
        rsp_ready <= ($urandom_range(99) >= 23);
      end
    end
  end

  initial begin
    dfpa_pkg::req_t r;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_directed();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 1000) begin
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
      end
      idle_gap(!(i >= 300 && i < 700));
      r.op = dfpa_pkg::op_t'($urandom_range(3));
      r.a_value = pick_value();
      r.b_value = pick_value();
      r.a_precision = pick_precision();
      r.b_precision = pick_precision();
      send_beat(r);
    end
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
